// ===== rtl/mqtf_pkg.sv =====
// Package for the multi-queue task FIFO: payload structs, command codes and
// default sizes. No dependencies; every other file imports it.
`default_nettype none

package mqtf_pkg;

  localparam int NUM_QUEUES_DEF  = 4;
  localparam int QUEUE_SLOTS_DEF = 16;

  localparam int CMD_W  = 2;
  localparam int QIDX_W = 2;
  localparam int TASK_W = 8;
  localparam int FREE_W = 4;

  // free_places saturates at the top of its field
  localparam int FREE_MAX = (1 << FREE_W) - 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_PEEK  = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_DROP  = 2'd2,
    CMD_CLEAR = 2'd3
  } mqtf_cmd_t;

  typedef struct packed {
    mqtf_cmd_t          command;
    logic [QIDX_W-1:0]  queue_index;
    logic [TASK_W-1:0]  task_id;
  } mqtf_in_t;

  typedef struct packed {
    logic               accepted;
    logic [TASK_W-1:0]  head_task;
    logic [FREE_W-1:0]  free_places;
  } mqtf_out_t;

  // per-transaction status from the pointer block to the result register
  typedef struct packed {
    logic               accepted;
    logic               nonempty;
    logic [FREE_W-1:0]  free_places;
  } mqtf_stat_t;

endpackage : mqtf_pkg

`default_nettype wire

// ===== rtl/mqtf_store.sv =====
// Task slot memory for all queues: one write port, one registered read port
// with write-to-read bypass. Depends on mqtf_pkg for the task width.
`default_nettype none

module mqtf_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [AW-1:0]              wr_addr,
  input  wire logic [mqtf_pkg::TASK_W-1:0] wr_data,
  input  wire logic                       rd_en,
  input  wire logic [AW-1:0]              rd_addr,
  output logic      [mqtf_pkg::TASK_W-1:0] rd_data_r
);
  import mqtf_pkg::*;

  logic [TASK_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // a task added to an empty queue is the new head in the same cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

endmodule : mqtf_store

`default_nettype wire

// ===== rtl/mqtf_ptrs.sv =====
// Head and tail pointers of every queue, command decode and free count.
// Drives the slot memory addresses. Depends on mqtf_pkg.
`default_nettype none

module mqtf_ptrs #(
  parameter int NUM_QUEUES  = mqtf_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_SLOTS = mqtf_pkg::QUEUE_SLOTS_DEF,
  parameter int AW          = 6
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step,
  input  wire mqtf_pkg::mqtf_in_t item,
  output logic                    wr_en,
  output logic [AW-1:0]           wr_addr,
  output logic [AW-1:0]           rd_addr,
  output mqtf_pkg::mqtf_stat_t    stat
);
  import mqtf_pkg::*;

  localparam int PW = $clog2(QUEUE_SLOTS);
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam logic [PW:0]   MAXF = (PW+1)'(QUEUE_SLOTS - 1);
  localparam logic [PW-1:0] LAST = PW'(QUEUE_SLOTS - 1);

  logic [PW-1:0] head_r [NUM_QUEUES];
  logic [PW-1:0] tail_r [NUM_QUEUES];

  logic          q_ok;
  logic [QW-1:0] qi;
  logic [PW-1:0] h, t, head_nxt, tail_nxt;
  logic [PW:0]   f_old, f_new;
  logic          add_ok;
  int            f_int;

  function automatic logic [PW:0] free_of(input logic [PW-1:0] hp, input logic [PW-1:0] tp);
    logic [PW:0] r;
    if (hp == tp) begin
      r = MAXF;
    end else if (hp < tp) begin
      r = MAXF - ((PW+1)'(tp) - (PW+1)'(hp));
    end else begin
      r = (PW+1)'(hp) - (PW+1)'(tp) - (PW+1)'(1);
    end
    return r;
  endfunction

  function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
    return (p == LAST) ? '0 : p + PW'(1);
  endfunction

  always_comb begin
    q_ok     = (int'(item.queue_index) < NUM_QUEUES);
    qi       = q_ok ? QW'(item.queue_index) : '0;
    h        = head_r[qi];
    t        = tail_r[qi];
    f_old    = free_of(h, t);
    head_nxt = h;
    tail_nxt = t;
    add_ok   = 1'b0;
    unique case (item.command)
      CMD_PEEK: begin
      end
      CMD_ADD: begin
        if (f_old != '0) begin
          add_ok   = 1'b1;
          tail_nxt = next_slot(t);
        end
      end
      CMD_DROP: begin
        if (h != t) begin
          head_nxt = next_slot(h);
        end
      end
      CMD_CLEAR: begin
        head_nxt = '0;
        tail_nxt = '0;
      end
      default: begin
      end
    endcase
    f_new = free_of(head_nxt, tail_nxt);
    f_int = int'(f_new);

    wr_en   = step && q_ok && add_ok;
    wr_addr = AW'(int'(qi) * QUEUE_SLOTS + int'(t));
    rd_addr = AW'(int'(qi) * QUEUE_SLOTS + int'(head_nxt));

    stat.accepted    = q_ok && add_ok;
    stat.nonempty    = q_ok && (head_nxt != tail_nxt);
    stat.free_places = !q_ok ? '0 :
                       (f_int > FREE_MAX) ? FREE_W'(FREE_MAX) : FREE_W'(f_int);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
      end
    end else if (step && q_ok) begin
      head_r[qi] <= head_nxt;
      tail_r[qi] <= tail_nxt;
    end
  end

endmodule : mqtf_ptrs

`default_nettype wire

// ===== rtl/multi_queue_task_fifo.sv =====
// Top level of the multi-queue task FIFO: input stage, result register and
// handshakes. Uses mqtf_ptrs, mqtf_store and mqtf_pkg.
//
//   port group   dir  handshake          payload
//   in_*         in   in_valid/in_ready  mqtf_in_t  (command, queue_index, task_id)
//   out_*        out  out_valid/out_ready mqtf_out_t (accepted, head_task, free_places)
//
// One transaction per cycle sustained while out_ready is high; each passes the input
// stage, then the result register loaded with the slot memory read of the new head.
// Synchronous active-low reset clears all head and tail pointers and both
// valid flags; the slot memory is not cleared and needs no sweep.
// A stalled result holds the input stage, which frees again as soon as the
// result is taken.
`default_nettype none

module multi_queue_task_fifo #(
  parameter int NUM_QUEUES  = mqtf_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_SLOTS = mqtf_pkg::QUEUE_SLOTS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire mqtf_pkg::mqtf_in_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output mqtf_pkg::mqtf_out_t      out_data
);
  import mqtf_pkg::*;

  localparam int DEPTH = NUM_QUEUES * QUEUE_SLOTS;
  localparam int AW    = $clog2(DEPTH);

  logic        stg_vld_r;
  mqtf_in_t    stg_item_r;
  logic        out_vld_r;
  mqtf_stat_t  stat_r;
  mqtf_stat_t  stat;
  logic        stg_adv;
  logic        wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [TASK_W-1:0] rd_data_r;

  assign stg_adv  = stg_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !stg_vld_r || stg_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else if (in_ready) begin
      stg_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stg_item_r <= in_data;
    end
  end

  mqtf_ptrs #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_SLOTS (QUEUE_SLOTS),
    .AW          (AW)
  ) u_ptrs (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (stg_adv),
    .item    (stg_item_r),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .rd_addr (rd_addr),
    .stat    (stat)
  );

  mqtf_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (stg_item_r.task_id),
    .rd_en     (stg_adv),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (stg_adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_adv) begin
      stat_r <= stat;
    end
  end

  assign out_valid            = out_vld_r;
  assign out_data.accepted    = stat_r.accepted;
  assign out_data.head_task   = stat_r.nonempty ? rd_data_r : '0;
  assign out_data.free_places = stat_r.free_places;

  // a stalled result must freeze the pointer update
  a_stall_no_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ready |-> !stg_adv)
    else $error("input stage advanced into a stalled result register");

  // hold the input stage while it cannot advance
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stg_vld_r && !stg_adv |=> stg_vld_r && $stable(stg_item_r))
    else $error("input stage lost or changed a waiting transaction");

  // a stored task leaves its queue non-empty
  a_add_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && stat_r.accepted |-> stat_r.nonempty)
    else $error("accepted add reported an empty queue");

endmodule : multi_queue_task_fifo

`default_nettype wire

// ===== test/mqtf_result_check.sv =====
// Result checker for the multi-queue task FIFO: watches both channels, predicts
// each result from its own copy of the queue pointers and slots, and compares.
// Depends on mqtf_pkg for the payload structs and command codes.
module mqtf_result_check (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  mqtf_pkg::mqtf_in_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  mqtf_pkg::mqtf_out_t out_data,
  output int                  mismatches,
  output int                  outstanding
);
  import mqtf_pkg::*;

  localparam int NQ    = NUM_QUEUES_DEF;
  localparam int NS    = QUEUE_SLOTS_DEF;
  localparam int PTR_W = $clog2(NS);

  logic [PTR_W-1:0]  head_at [NQ];
  logic [PTR_W-1:0]  tail_at [NQ];
  logic [TASK_W-1:0] slots   [NQ*NS];
  mqtf_out_t         awaited_results [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
    for (int i = 0; i < NQ*NS; i++) slots[i] = '0;
  end

  function automatic int unsigned room(int q);
    int unsigned h, t;
    h = head_at[q];
    t = tail_at[q];
    if (h == t) return NS - 1;
    if (h < t) return NS - 1 - (t - h);
    return h - t - 1;
  endfunction

  function automatic logic [PTR_W-1:0] step_ptr(logic [PTR_W-1:0] p);
    return (p == PTR_W'(NS - 1)) ? '0 : p + 1'b1;
  endfunction

  // Apply one command to the queue state and return the result it produces.
  function automatic mqtf_out_t apply_command(mqtf_in_t item);
    mqtf_out_t   res;
    int          q;
    int unsigned f;
    res = '0;
    q   = int'(item.queue_index);
    if (q < NQ) begin
      f = room(q);
      case (item.command)
        CMD_ADD: begin
          if (f != 0) begin
            slots[q*NS + int'(tail_at[q])] = item.task_id;
            tail_at[q] = step_ptr(tail_at[q]);
            res.accepted = 1'b1;
          end
        end
        CMD_DROP: begin
          if (f < NS - 1) head_at[q] = step_ptr(head_at[q]);
        end
        CMD_CLEAR: begin
          head_at[q] = '0;
          tail_at[q] = '0;
        end
        default: ;
      endcase
      f = room(q);
      if (f < NS - 1) res.head_task = slots[q*NS + int'(head_at[q])];
      res.free_places = (f > FREE_MAX) ? FREE_W'(FREE_MAX) : FREE_W'(f);
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    mqtf_out_t want;
    if (!rst_n) begin
      for (int i = 0; i < NQ; i++) begin
        head_at[i] = '0;
        tail_at[i] = '0;
      end
      awaited_results.delete();
    end else begin
      // compare before pushing: a result can never belong to this edge's input
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $error("result transaction with no result awaited: %p", out_data);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          if (out_data.accepted !== want.accepted) begin
            $error("accepted: expected %0d, got %0d", want.accepted, out_data.accepted);
            mismatches++;
          end
          if (out_data.head_task !== want.head_task) begin
            $error("head_task: expected %0d, got %0d", want.head_task, out_data.head_task);
            mismatches++;
          end
          if (out_data.free_places !== want.free_places) begin
            $error("free_places: expected %0d, got %0d",
                   want.free_places, out_data.free_places);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) awaited_results.push_back(apply_command(in_data));
    end
    outstanding <= awaited_results.size();
  end

endmodule

// ===== test/multi_queue_task_fifo_tb.sv =====
// Top of the multi-queue task FIFO testbench: clock, reset, command stimulus
// and result-side backpressure. Uses mqtf_pkg, mqtf_result_check and the RTL.
module multi_queue_task_fifo_tb;
  import mqtf_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int NQ          = NUM_QUEUES_DEF;
  localparam int NS          = QUEUE_SLOTS_DEF;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  mqtf_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  mqtf_out_t out_data;
  int        mismatches;
  int        outstanding;
  int        cycles = 0;
  bit        calm = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  multi_queue_task_fifo dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  mqtf_result_check check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("multi_queue_task_fifo test failed");
      $finish;
    end
  end

  // mostly short pauses, a few long ones, none during a calm stretch
  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 20);
  endfunction

  function automatic mqtf_in_t mk(mqtf_cmd_t cmd, int q, int id);
    mqtf_in_t item;
    item.command     = cmd;
    item.queue_index = QIDX_W'(q);
    item.task_id     = TASK_W'(id);
    return item;
  endfunction

  // fill_bias: percent chance of an add; focus: queue most commands address
  function automatic mqtf_in_t random_command(int fill_bias, int focus);
    mqtf_cmd_t cmd;
    int        r, q;
    r = $urandom_range(0, 99);
    if (r < fill_bias) cmd = CMD_ADD;
    else begin
      r = $urandom_range(0, 99);
      if (r < 5) cmd = CMD_CLEAR;
      else if (r < 30) cmd = CMD_PEEK;
      else cmd = CMD_DROP;
    end
    q = ($urandom_range(0, 9) < 7) ? focus : $urandom_range(0, (1 << QIDX_W) - 1);
    return mk(cmd, q, $urandom_range(0, 255));
  endfunction

  task automatic send(mqtf_in_t item);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin : ready_ctl
    int n;
    while (!rst_n) @(posedge clk);
    forever begin
      n = $urandom_range(1, 12);
      out_ready <= 1'b1;
      repeat (n) @(posedge clk);
      n = idle_len();
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int mode, bias, focus;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty peek, extreme ids, drop and clear, fill to full, refused add
    send(mk(CMD_PEEK, 0, 0));
    send(mk(CMD_ADD, 1, 255));
    send(mk(CMD_ADD, 1, 0));
    send(mk(CMD_PEEK, 1, 0));
    send(mk(CMD_DROP, 1, 0));
    send(mk(CMD_CLEAR, 1, 0));
    send(mk(CMD_DROP, 1, 0));
    for (int i = 0; i < NS - 1; i++) send(mk(CMD_ADD, 3, 16 * i + i));
    send(mk(CMD_ADD, 3, 170));
    send(mk(CMD_CLEAR, 3, 0));
    send(mk(CMD_PEEK, 2, 85));

    // random: blocks that lean toward filling, draining or neither
    for (int blk = 0; blk < 10; blk++) begin
      calm  = ($urandom_range(0, 3) == 0);
      mode  = $urandom_range(0, 2);
      bias  = (mode == 0) ? 75 : (mode == 1) ? 25 : 50;
      focus = $urandom_range(0, NQ - 1);
      for (int k = 0; k < 50; k++) send(random_command(bias, focus));
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("multi_queue_task_fifo test passed");
    end else begin
      $display("multi_queue_task_fifo test failed");
    end
    $finish;
  end

endmodule

// ===== multi_queue_task_fifo.f =====
rtl/mqtf_pkg.sv
rtl/mqtf_store.sv
rtl/mqtf_ptrs.sv
rtl/multi_queue_task_fifo.sv
test/mqtf_result_check.sv
test/multi_queue_task_fifo_tb.sv
